/* rtl/core/clook_pkg.sv */
// ---------------------------------------------------------------------------
// clook_pkg
// Types and constants shared by the c-look disk scheduler modules: item
// payloads, controller states and the command and status groups.
// ---------------------------------------------------------------------------
package clook_pkg;

   localparam int TRACK_W = 16;
   localparam int SUM_W   = 24;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   // one request item
   typedef struct packed {
      logic [TRACK_W-1:0] track;
      logic               last_request;
   } req_type;

   // one result item
   typedef struct packed {
      logic [TRACK_W-1:0] track_served;
      logic [SUM_W-1:0]   head_travel;
      logic               last_served;
      logic               overflow;
   } rsp_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;        // store the incoming item
      logic batch_init;  // load head position for a new batch
      logic scan_clear;  // restart the minimum search
      logic scan_read;   // read one stored entry and advance
      logic emit;        // present the selected entry as a result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;   // read issued for the last stored entry
      logic batch_done;  // the result being emitted is the final one
   } sts_type;

endpackage

/* rtl/core/clook_ram.sv */
// ---------------------------------------------------------------------------
// clook_ram
// Generic single write port, single read port memory with registered read.
// ---------------------------------------------------------------------------
module clook_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/clook_ctrl.sv */
// ---------------------------------------------------------------------------
// clook_ctrl
// Controller of the c-look scheduler: loads items while idle, then for each
// result runs a scan over the stored requests and emits the selected one.
// ---------------------------------------------------------------------------
module clook_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_last,
   input  clook_pkg::sts_type  sts,
   output clook_pkg::cmd_type  cmd,
   output logic                busy,
   output logic                rsp_valid
);

   clook_pkg::state_type state_ff;
   clook_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clook_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clook_pkg::ST_IDLE: begin
            if (start && req_last) begin
               state_in = clook_pkg::ST_SCAN;
            end
         end
         clook_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = clook_pkg::ST_DRAIN;
            end
         end
         clook_pkg::ST_DRAIN: begin
            state_in = clook_pkg::ST_EMIT;
         end
         clook_pkg::ST_EMIT: begin
            if (sts.batch_done) begin
               state_in = clook_pkg::ST_IDLE;
            end else begin
               state_in = clook_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = clook_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         clook_pkg::ST_IDLE: begin
            busy           = 1'b0;
            cmd.load       = start;
            cmd.batch_init = start && req_last;
            cmd.scan_clear = start && req_last;
         end
         clook_pkg::ST_SCAN: begin
            cmd.scan_read = 1'b1;
         end
         clook_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         clook_pkg::ST_EMIT: begin
            cmd.emit       = 1'b1;
            cmd.scan_clear = 1'b1;
            rsp_valid      = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // a result always follows the drain of a scan
   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == clook_pkg::ST_EMIT) |-> ($past(state_ff) == clook_pkg::ST_DRAIN))
      else $error("result emitted without a completed scan");

   // a closing item always starts a scan
   a_close_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (!busy && start && req_last) |=> (state_ff == clook_pkg::ST_SCAN))
      else $error("closing item did not start scheduling");

endmodule

/* rtl/core/clook_datapath.sv */
// ---------------------------------------------------------------------------
// clook_datapath
// Request store, head start register and the minimum search that picks the
// next track in c-look order, with head movement accumulation.
// ---------------------------------------------------------------------------
module clook_datapath #(
   parameter int MAX_REQUESTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  clook_pkg::cmd_type                   cmd,
   output clook_pkg::sts_type                   sts,
   input  clook_pkg::req_type                   req_data,
   input  logic                                 csr_wr,
   input  logic [clook_pkg::TRACK_W-1:0]        csr_data,
   output clook_pkg::rsp_type                   rsp_data
);

   localparam int IDX_W = $clog2(MAX_REQUESTS);
   localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
   localparam int KEY_W = clook_pkg::TRACK_W + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

   logic [clook_pkg::TRACK_W-1:0] head_start_ff;
   logic [CNT_W-1:0]              count_ff;
   logic [CNT_W-1:0]              count_in;
   logic                          dropped_ff;
   logic                          dropped_in;
   logic [IDX_W-1:0]              scan_idx_ff;
   logic [IDX_W-1:0]              scan_idx_in;
   logic                          cmp_valid_ff;
   logic [IDX_W-1:0]              cmp_idx_ff;
   logic                          best_valid_ff;
   logic                          best_valid_in;
   logic [KEY_W-1:0]              best_key_ff;
   logic [KEY_W-1:0]              best_key_in;
   logic [IDX_W-1:0]              best_idx_ff;
   logic [IDX_W-1:0]              best_idx_in;
   logic [MAX_REQUESTS-1:0]       served_ff;
   logic [MAX_REQUESTS-1:0]       served_in;
   logic [CNT_W-1:0]              served_cnt_ff;
   logic [CNT_W-1:0]              served_cnt_in;
   logic [clook_pkg::TRACK_W-1:0] head_ff;
   logic [clook_pkg::TRACK_W-1:0] head_in;
   logic [clook_pkg::SUM_W-1:0]   sum_ff;
   logic [clook_pkg::SUM_W-1:0]   sum_in;

   logic                          wr_en;
   logic [clook_pkg::TRACK_W-1:0] rd_data;
   logic [KEY_W-1:0]              rd_key;
   logic [clook_pkg::TRACK_W-1:0] best_track;
   logic [clook_pkg::TRACK_W-1:0] step_len;
   logic [clook_pkg::SUM_W:0]     sum_ext;
   logic [clook_pkg::SUM_W-1:0]   sum_sat;

   // request store
   assign wr_en = cmd.load && (count_ff < CNT_MAX);

   clook_ram #(
      .WIDTH(clook_pkg::TRACK_W),
      .DEPTH(MAX_REQUESTS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[IDX_W-1:0]),
      .wr_data(req_data.track),
      .rd_addr(scan_idx_ff),
      .rd_data(rd_data)
   );

   // head start register
   always_ff @(posedge clock) begin
      if (reset) begin
         head_start_ff <= '0;
      end else if (csr_wr) begin
         head_start_ff <= csr_data;
      end
   end

   // tracks below the head sort after all tracks at or above it
   assign rd_key     = {rd_data < head_start_ff, rd_data};
   assign best_track = best_key_ff[clook_pkg::TRACK_W-1:0];

   // head movement for the selected track, saturating
   assign step_len = (best_track >= head_ff) ? (best_track - head_ff) : (head_ff - best_track);
   assign sum_ext  = {1'b0, sum_ff} + (clook_pkg::SUM_W + 1)'(step_len);
   assign sum_sat  = sum_ext[clook_pkg::SUM_W] ? clook_pkg::SUM_MAX
                                               : sum_ext[clook_pkg::SUM_W-1:0];

   // status towards the controller
   assign sts.scan_done  = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff;
   assign sts.batch_done = (served_cnt_ff + CNT_W'(1)) == count_ff;

   // load counter and drop flag
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.emit && sts.batch_done) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.load) begin
         if (count_ff < CNT_MAX) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   // scan index and minimum search
   always_comb begin
      scan_idx_in   = scan_idx_ff;
      best_valid_in = best_valid_ff;
      best_key_in   = best_key_ff;
      best_idx_in   = best_idx_ff;
      if (cmd.scan_clear) begin
         scan_idx_in   = '0;
         best_valid_in = 1'b0;
      end else begin
         if (cmd.scan_read) begin
            scan_idx_in = scan_idx_ff + IDX_W'(1);
         end
         if (cmp_valid_ff && !served_ff[cmp_idx_ff] &&
             (!best_valid_ff || (rd_key < best_key_ff))) begin
            best_valid_in = 1'b1;
            best_key_in   = rd_key;
            best_idx_in   = cmp_idx_ff;
         end
      end
   end

   // served marks, head position and movement sum
   always_comb begin
      served_in     = served_ff;
      served_cnt_in = served_cnt_ff;
      head_in       = head_ff;
      sum_in        = sum_ff;
      if (cmd.batch_init) begin
         head_in = csr_wr ? csr_data : head_start_ff;
         sum_in  = '0;
      end
      if (cmd.emit) begin
         head_in = best_track;
         if (sts.batch_done) begin
            served_in     = '0;
            served_cnt_in = '0;
            sum_in        = '0;
         end else begin
            served_in[best_idx_ff] = 1'b1;
            served_cnt_in          = served_cnt_ff + CNT_W'(1);
            sum_in                 = sum_sat;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         scan_idx_ff   <= '0;
         cmp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         served_ff     <= '0;
         served_cnt_ff <= '0;
         head_ff       <= '0;
         sum_ff        <= '0;
      end else begin
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         scan_idx_ff   <= scan_idx_in;
         cmp_valid_ff  <= cmd.scan_read;
         best_valid_ff <= best_valid_in;
         served_ff     <= served_in;
         served_cnt_ff <= served_cnt_in;
         head_ff       <= head_in;
         sum_ff        <= sum_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff  <= scan_idx_ff;
      best_key_ff <= best_key_in;
      best_idx_ff <= best_idx_in;
   end

   // result item
   always_comb begin
      rsp_data.track_served = best_track;
      rsp_data.last_served  = sts.batch_done;
      rsp_data.head_travel  = sts.batch_done ? sum_sat : '0;
      rsp_data.overflow     = sts.batch_done && dropped_ff;
   end

   // the store never holds more than its capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("request count beyond capacity");

   // every emitted entry was found by the scan and not served before
   a_emit_fresh: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (best_valid_ff && !served_ff[best_idx_ff]))
      else $error("emitted entry not selected or already served");

   // the final result leaves an empty store behind
   a_batch_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.batch_done) |=> (count_ff == '0 && served_ff == '0 && !dropped_ff))
      else $error("batch state not cleared after final result");

endmodule

/* rtl/core/clook_disk_scheduler.sv */
// ---------------------------------------------------------------------------
// clook_disk_scheduler
// C-look disk scheduler: collects a batch of track requests, then serves
// them upward from the configured head position, wraps to the lowest track
// and reports the total head movement on the final result.
// ---------------------------------------------------------------------------
// A request item is taken whenever start is high and busy is low. The item
// marked last closes the batch; busy then stays high while the results come
// out. Every result needs a full scan of the request store, one entry per
// cycle through its single read port, then the registered read and the
// result itself, so no new request item is taken before the batch is
// served. A result is shown for exactly one cycle with rsp_valid and cannot
// be held off by the receiver. Requests past MAX_REQUESTS are dropped and
// flagged on the final result. The head start register may be written at
// any time the block is not busy.
module clook_disk_scheduler #(
   parameter int MAX_REQUESTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  clook_pkg::req_type            req_data,
   // result channel
   output logic                          rsp_valid,
   output clook_pkg::rsp_type            rsp_data,
   // head start register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [clook_pkg::TRACK_W-1:0] csr_data
);

   clook_pkg::cmd_type cmd;
   clook_pkg::sts_type sts;

   // the register takes a write only while no batch is in service
   assign csr_ready = !busy;

   // sequencer
   clook_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_data.last_request),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   // store, search and movement datapath
   clook_datapath #(
      .MAX_REQUESTS(MAX_REQUESTS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .sts     (sts),
      .req_data(req_data),
      .csr_wr  (csr_valid && csr_ready),
      .csr_data(csr_data),
      .rsp_data(rsp_data)
   );

endmodule

/* tb/clook_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// clook_checker
// Watches the request, result and head start channels of the c-look disk
// scheduler. Keeps its own copy of the pending batch and the head start
// register, works out the service order when a batch closes and compares
// each result item, field by field, with the oldest predicted one.
// ---------------------------------------------------------------------------
module clook_checker #(
   parameter int MAX_REQUESTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  clook_pkg::req_type            req_data,
   input  logic                          rsp_valid,
   input  clook_pkg::rsp_type            rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [clook_pkg::TRACK_W-1:0] csr_data,
   output int                            error_count,
   output int                            outstanding
);

   logic [clook_pkg::TRACK_W-1:0] head_start_copy;
   logic [clook_pkg::TRACK_W-1:0] batch_tracks [MAX_REQUESTS];
   int                            batch_len;
   logic                          batch_dropped;
   clook_pkg::rsp_type            due_results [$];

   function automatic void flag_error(string what);
      if (error_count < 10)
         $display("%0t ERROR: %s", $time, what);
      error_count++;
   endfunction

   // sort the closed batch and queue its results in c-look service order
   function automatic void serve_batch();
      logic [clook_pkg::TRACK_W-1:0] order [MAX_REQUESTS];
      logic [clook_pkg::TRACK_W-1:0] v;
      logic [clook_pkg::TRACK_W-1:0] head;
      logic [clook_pkg::SUM_W:0]     travel;
      clook_pkg::rsp_type            res;
      int                            k;
      int                            first;
      int                            idx;
      for (int i = 0; i < batch_len; i++)
         order[i] = batch_tracks[i];
      for (int i = 1; i < batch_len; i++) begin
         v = order[i];
         k = i;
         while (k > 0 && order[k-1] > v) begin
            order[k] = order[k-1];
            k--;
         end
         order[k] = v;
      end
      // lowest track at or above the head, none gives an empty upward sweep
      first = batch_len;
      for (int i = batch_len - 1; i >= 0; i--)
         if (order[i] >= head_start_copy)
            first = i;
      head   = head_start_copy;
      travel = '0;
      for (int i = 0; i < batch_len; i++) begin
         idx = (first + i) % batch_len;
         travel = travel + ((order[idx] >= head) ? order[idx] - head : head - order[idx]);
         if (travel > {1'b0, clook_pkg::SUM_MAX})
            travel = {1'b0, clook_pkg::SUM_MAX};
         head = order[idx];
         res = '0;
         res.track_served = order[idx];
         if (i == batch_len - 1) begin
            res.head_travel = travel[clook_pkg::SUM_W-1:0];
            res.last_served = 1'b1;
            res.overflow    = batch_dropped;
         end
         due_results.push_back(res);
      end
      batch_len     = 0;
      batch_dropped = 1'b0;
   endfunction

   // sample all channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         head_start_copy = '0;
         batch_len       = 0;
         batch_dropped   = 1'b0;
         due_results.delete();
         error_count     = 0;
      end else begin
         // results first: none can leave at the edge that closes a batch
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               flag_error($sformatf("unexpected result item, track %0d",
                                    rsp_data.track_served));
            end else begin
               if (rsp_data.track_served !== due_results[0].track_served ||
                   rsp_data.head_travel  !== due_results[0].head_travel  ||
                   rsp_data.last_served  !== due_results[0].last_served  ||
                   rsp_data.overflow     !== due_results[0].overflow)
                  flag_error($sformatf(
                     {"result item track/travel/last/overflow ",
                      "expected %0d/%0d/%b/%b got %0d/%0d/%b/%b"},
                     due_results[0].track_served, due_results[0].head_travel,
                     due_results[0].last_served, due_results[0].overflow,
                     rsp_data.track_served, rsp_data.head_travel,
                     rsp_data.last_served, rsp_data.overflow));
               void'(due_results.pop_front());
            end
         end
         if (csr_valid && csr_ready)
            head_start_copy = csr_data;
         // request item taken
         if (start && !busy) begin
            if (batch_len < MAX_REQUESTS) begin
               batch_tracks[batch_len] = req_data.track;
               batch_len++;
            end else begin
               batch_dropped = 1'b1;
            end
            if (req_data.last_request)
               serve_batch();
         end
      end
      outstanding = due_results.size();
   end

endmodule

/* tb/tb_clook_disk_scheduler.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_clook_disk_scheduler
// Drives request batches and head start writes into the c-look disk
// scheduler: a directed opening on the track extremes, a head hit, a wrap,
// an empty upward sweep and a full store, then random batches in three
// phases of sender idling. The checker beside the block judges each result.
// ---------------------------------------------------------------------------
module tb_clook_disk_scheduler;

   localparam int MAX_REQUESTS = 16;
   localparam int PHASE_ITEMS  = 75;

   typedef enum int {
      SPREAD_ANY,
      NEAR_HEAD,
      FEW_VALUES,
      EXTREMES
   } spread_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   clook_pkg::req_type            req_data;
   logic                          rsp_valid;
   clook_pkg::rsp_type            rsp_data;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [clook_pkg::TRACK_W-1:0] csr_data;
   int                            error_count;
   int                            outstanding;
   logic [clook_pkg::TRACK_W-1:0] cur_head;
   int                            sent;

   clook_disk_scheduler #(
      .MAX_REQUESTS(MAX_REQUESTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   clook_checker #(
      .MAX_REQUESTS(MAX_REQUESTS)
   ) order_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // one request item, after random idle cycles; returns at the falling edge
   task automatic send_request(logic [clook_pkg::TRACK_W-1:0] trk, logic last,
                               int idle_pct);
      clook_pkg::req_type item;
      item.track        = trk;
      item.last_request = last;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   // wait until every predicted result has come and the block is idle
   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 || busy)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_head(logic [clook_pkg::TRACK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_head = value;
   endtask

   function automatic logic [clook_pkg::TRACK_W-1:0] pick_track(spread_type spread);
      int t;
      case (spread)
         SPREAD_ANY: t = $urandom_range(65535);
         NEAR_HEAD:  t = int'(cur_head) + int'($urandom_range(80)) - 40;
         FEW_VALUES: t = int'($urandom_range(3)) * 21845;
         default:    t = ($urandom_range(1) != 0) ? 65535 : 0;
      endcase
      if (t < 0)
         t = 0;
      if (t > 65535)
         t = 65535;
      return t[clook_pkg::TRACK_W-1:0];
   endfunction

   // random batches, mostly small, a few past the store capacity
   task automatic run_phase(int idle_pct);
      int         target;
      int         size;
      int         pick;
      spread_type spread;
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
         pick = $urandom_range(99);
         if (pick < 60)
            size = $urandom_range(5, 1);
         else if (pick < 90)
            size = $urandom_range(16, 6);
         else
            size = $urandom_range(20, 17);
         if ($urandom_range(3) == 0) begin
            settle();
            pick = $urandom_range(99);
            write_head(pick < 15 ? 16'h0000 :
                       pick < 30 ? 16'hFFFF : 16'($urandom_range(65535)));
         end
         spread = spread_type'($urandom_range(3));
         for (int i = 0; i < size; i++)
            send_request(pick_track(spread), i == size - 1, idle_pct);
         sent += size;
      end
   endtask

   // stimulus and verdict
   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      cur_head  = '0;
      sent      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single request batches on both track extremes, head at reset value
      send_request(16'h0000, 1'b1, 0);
      send_request(16'hFFFF, 1'b1, 0);
      settle();
      write_head(16'd40000);
      // upward sweep, a track on the head itself and a wrap to the lowest
      send_request(16'd50000, 1'b0, 0);
      send_request(16'd10, 1'b0, 0);
      send_request(16'd40000, 1'b0, 0);
      send_request(16'd39999, 1'b1, 0);
      settle();
      write_head(16'hFFFF);
      // nothing at or above the head
      send_request(16'd3, 1'b0, 0);
      send_request(16'd1, 1'b1, 0);
      // full store: two extra items dropped, the second one closing the batch
      for (int i = 0; i < MAX_REQUESTS + 2; i++)
         send_request(16'(i * 3851), i == MAX_REQUESTS + 1, 0);
      settle();
      write_head(16'h0000);

      run_phase(29);
      run_phase(87);
      run_phase(0);

      settle();
      repeat (20) @(negedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
